// ===== rtl/core/enacc_pkg.sv =====
// shared widths, constants and control structs for the error norm accumulator
package enacc_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int DIFF_W    = 24;
    localparam int SQ_W      = 48;
    localparam int ABS_SUM_W = 44;
    localparam int SQ_SUM_W  = 64;
    localparam int CNT_W     = 21;
    localparam int ROOT_W    = 32;
    localparam int REM_W     = 36;
    localparam int QUO_W     = 44;
    localparam int STEP_W    = 6;

    localparam logic [CNT_W-1:0] MAX_PAIRS = CNT_W'(1048576);

    // bit steps of the shift-subtract unit for each pass
    localparam logic [STEP_W-1:0] ROOT_STEPS = STEP_W'(32);
    localparam logic [STEP_W-1:0] RMS_STEPS  = STEP_W'(32);
    localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(44);

    // accumulator control from the sequencer
    typedef struct packed {
        logic capture;
        logic diff;
        logic square;
        logic update;
        logic clear;
    } t_acc_ctrl;

    // start request for the shift-subtract unit
    typedef struct packed {
        logic              start;
        logic              sqrt_mode;
        logic [STEP_W-1:0] steps;
    } t_ds_req;

    // status back from the shift-subtract unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_ds_stat;

endpackage

// ===== rtl/core/enacc_accum.sv =====
// per-pair datapath: sign match, absolute difference, square and running sums
module enacc_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  enacc_pkg::t_acc_ctrl                i_ctrl,
    input  logic                                i_sign_match,
    input  logic signed [enacc_pkg::SAMPLE_W-1:0] i_reference_value,
    input  logic signed [enacc_pkg::SAMPLE_W-1:0] i_estimate_value,
    input  logic                                i_last_pair,
    output logic                                o_last,
    output logic [enacc_pkg::ABS_SUM_W-1:0]     o_abs_sum,
    output logic [enacc_pkg::SQ_SUM_W-1:0]      o_square_sum,
    output logic [enacc_pkg::DIFF_W-1:0]        o_abs_max,
    output logic [enacc_pkg::CNT_W-1:0]         o_pairs_seen,
    output logic                                o_overflow_seen
);

    localparam int SW = enacc_pkg::SAMPLE_W;

    logic signed [SW-1:0]                r_ref;
    logic signed [SW-1:0]                r_est;
    logic                                r_last;
    logic [enacc_pkg::DIFF_W-1:0]        r_d;
    logic [enacc_pkg::SQ_W-1:0]          r_sq;
    logic [enacc_pkg::ABS_SUM_W-1:0]     r_abs_sum;
    logic [enacc_pkg::SQ_SUM_W-1:0]      r_square_sum;
    logic [enacc_pkg::DIFF_W-1:0]        r_abs_max;
    logic [enacc_pkg::CNT_W-1:0]         r_pairs_seen;
    logic                                r_overflow_seen;

    logic signed [SW-1:0]                est_adj;
    logic signed [SW:0]                  diff;
    logic [SW:0]                         diff_abs;
    logic [enacc_pkg::ABS_SUM_W:0]       abs_sum_wide;
    logic [enacc_pkg::SQ_SUM_W:0]        sq_sum_wide;
    logic                                flip;

    // zero counts as non-negative, so the sign bit alone decides
    always_comb begin
        flip = i_sign_match & (r_ref[SW-1] != r_est[SW-1]);
        if (!flip) begin
            est_adj = r_est;
        end else if (r_est == {1'b1, {(SW-1){1'b0}}}) begin
            est_adj = {1'b0, {(SW-1){1'b1}}};
        end else begin
            est_adj = -r_est;
        end
        diff     = {r_ref[SW-1], r_ref} - {est_adj[SW-1], est_adj};
        diff_abs = diff[SW] ? (SW+1)'(-diff) : diff;
    end

    assign abs_sum_wide = {1'b0, r_abs_sum} + (enacc_pkg::ABS_SUM_W+1)'(r_d);
    assign sq_sum_wide  = {1'b0, r_square_sum} + (enacc_pkg::SQ_SUM_W+1)'(r_sq);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_ref  <= i_reference_value;
            r_est  <= i_estimate_value;
            r_last <= i_last_pair;
        end
        if (i_ctrl.diff) begin
            r_d <= diff_abs[enacc_pkg::DIFF_W-1:0];
        end
        if (i_ctrl.square) begin
            r_sq <= r_d * r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_abs_sum       <= '0;
            r_square_sum    <= '0;
            r_abs_max       <= '0;
            r_pairs_seen    <= '0;
            r_overflow_seen <= 1'b0;
        end else if (i_ctrl.update) begin
            if (r_pairs_seen >= enacc_pkg::MAX_PAIRS) begin
                r_overflow_seen <= 1'b1;
            end else begin
                if (r_d > r_abs_max) begin
                    r_abs_max <= r_d;
                end
                r_abs_sum <= abs_sum_wide[enacc_pkg::ABS_SUM_W] ? '1
                           : abs_sum_wide[enacc_pkg::ABS_SUM_W-1:0];
                if (sq_sum_wide[enacc_pkg::SQ_SUM_W]) begin
                    r_square_sum    <= '1;
                    r_overflow_seen <= 1'b1;
                end else begin
                    r_square_sum <= sq_sum_wide[enacc_pkg::SQ_SUM_W-1:0];
                end
                r_pairs_seen <= r_pairs_seen + 1'b1;
            end
        end
    end

    assign o_last          = r_last;
    assign o_abs_sum       = r_abs_sum;
    assign o_square_sum    = r_square_sum;
    assign o_abs_max       = r_abs_max;
    assign o_pairs_seen    = r_pairs_seen;
    assign o_overflow_seen = r_overflow_seen;

endmodule

// ===== rtl/core/enacc_shiftsub.sv =====
// shared shift-subtract unit: one bit per cycle of integer square root or division
module enacc_shiftsub (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  enacc_pkg::t_ds_req              i_req,
    input  logic [enacc_pkg::SQ_SUM_W-1:0]  i_operand,
    input  logic [enacc_pkg::CNT_W-1:0]     i_divisor,
    output enacc_pkg::t_ds_stat             o_stat,
    output logic [enacc_pkg::QUO_W-1:0]     o_quotient
);

    localparam int RW = enacc_pkg::REM_W;
    localparam int OW = enacc_pkg::SQ_SUM_W;
    localparam int QW = enacc_pkg::QUO_W;

    logic [RW-1:0]                 r_rem;
    logic [OW-1:0]                 r_opnd;
    logic [QW-1:0]                 r_quo;
    logic [enacc_pkg::STEP_W-1:0]  r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic                          r_sqrt;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          fits;

    // root: bring down two bits, try 4r+1; divide: bring down one bit, try the divisor
    always_comb begin
        if (r_sqrt) begin
            rem_sh = {r_rem[RW-3:0], r_opnd[OW-1:OW-2]};
            trial  = {r_quo[RW-3:0], 2'b01};
        end else begin
            rem_sh = {r_rem[RW-2:0], r_opnd[OW-1]};
            trial  = RW'(i_divisor);
        end
        fits = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == enacc_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quo  <= '0;
            r_opnd <= i_operand;
            r_sqrt <= i_req.sqrt_mode;
        end else if (r_busy) begin
            r_rem  <= fits ? rem_sh - trial : rem_sh;
            r_quo  <= {r_quo[QW-2:0], fits};
            r_opnd <= r_sqrt ? {r_opnd[OW-3:0], 2'b00} : {r_opnd[OW-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== rtl/core/error_norm_accumulator.sv =====
// top level: pair sequencer, final-statistics sequencing and the result register
//
// Takes signed Q8.16 (reference, estimate) pairs and keeps the L1, saturating L2
// and Linf statistics of the set. An ordinary pair passes through capture,
// difference, square and accumulate before the input is ready again; the
// 24x24 squaring sits in a stage of its own. A pair flagged last is followed
// by the closing pass on one shared shift-subtract unit: a 32-step integer
// square root of the sum of squares, a 32-step division of that root by the
// count and a 44-step division of the absolute sum by the count, and the
// input is ready again only once that pass is over and the result has been
// loaded, which waits for the result register to free up if needed. The
// result sits in an output register, so the next set may start while it waits
// to be taken; only a following last pair waits for the register to free up.
// Set sign_match_enable through i_cfg_we / i_cfg_data while the block is idle.
module error_norm_accumulator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_data,
    // input beat
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [enacc_pkg::SAMPLE_W-1:0] i_reference_value,
    input  logic signed [enacc_pkg::SAMPLE_W-1:0] i_estimate_value,
    input  logic                                  i_last_pair,
    // result beat
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [enacc_pkg::DIFF_W-1:0]          o_mean_abs_error,
    output logic [enacc_pkg::ROOT_W-1:0]          o_root_sq_over_count,
    output logic [enacc_pkg::DIFF_W-1:0]          o_max_abs_error,
    output logic [enacc_pkg::CNT_W-1:0]           o_pair_count,
    output logic                                  o_empty_set,
    output logic                                  o_saturated
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // ready for a beat
    localparam logic [2:0] S_DIFF = 3'd1;  // absolute difference
    localparam logic [2:0] S_SQR  = 3'd2;  // square of the difference
    localparam logic [2:0] S_ACC  = 3'd3;  // update the running sums
    localparam logic [2:0] S_FIN  = 3'd4;  // last pair: decide on the closing pass
    localparam logic [2:0] S_ROOT = 3'd5;  // square root running
    localparam logic [2:0] S_RMS  = 3'd6;  // root / count running
    localparam logic [2:0] S_MEAN = 3'd7;  // abs sum / count running, then emit

    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic                                r_sign_match;
    logic [enacc_pkg::ROOT_W-1:0]        r_rms;
    logic                                r_emit;
    logic                                r_out_valid;
    logic [enacc_pkg::DIFF_W-1:0]        r_mean;
    logic [enacc_pkg::ROOT_W-1:0]        r_root_out;
    logic [enacc_pkg::DIFF_W-1:0]        r_max;
    logic [enacc_pkg::CNT_W-1:0]         r_count;
    logic                                r_empty;
    logic                                r_sat;

    enacc_pkg::t_acc_ctrl                acc_ctrl;
    enacc_pkg::t_ds_req                  ds_req;
    enacc_pkg::t_ds_stat                 ds_stat;
    logic [enacc_pkg::SQ_SUM_W-1:0]      ds_operand;
    logic [enacc_pkg::QUO_W-1:0]         ds_quo;

    logic                                acc_last;
    logic [enacc_pkg::ABS_SUM_W-1:0]     abs_sum;
    logic [enacc_pkg::SQ_SUM_W-1:0]      square_sum;
    logic [enacc_pkg::DIFF_W-1:0]        abs_max;
    logic [enacc_pkg::CNT_W-1:0]         pairs_seen;
    logic                                overflow_seen;

    logic                                in_beat;
    logic                                out_free;
    logic                                set_empty;
    logic                                load_out;

    assign in_beat   = i_valid & o_ready;
    assign out_free  = ~r_out_valid | i_ready;
    assign set_empty = pairs_seen == '0;

    // the result is loaded once the closing pass is over and the register is free
    assign load_out = r_emit & out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign_match <= 1'b0;
        end else if (i_cfg_we) begin
            r_sign_match <= i_cfg_data;
        end
    end

    enacc_accum u_accum (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (acc_ctrl),
        .i_sign_match      (r_sign_match),
        .i_reference_value (i_reference_value),
        .i_estimate_value  (i_estimate_value),
        .i_last_pair       (i_last_pair),
        .o_last            (acc_last),
        .o_abs_sum         (abs_sum),
        .o_square_sum      (square_sum),
        .o_abs_max         (abs_max),
        .o_pairs_seen      (pairs_seen),
        .o_overflow_seen   (overflow_seen)
    );

    enacc_shiftsub u_shiftsub (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (ds_req),
        .i_operand  (ds_operand),
        .i_divisor  (pairs_seen),
        .o_stat     (ds_stat),
        .o_quotient (ds_quo)
    );

    // sequencer
    always_comb begin
        n_state         = r_state;
        acc_ctrl        = '0;
        ds_req          = '0;
        ds_operand      = square_sum;
        acc_ctrl.clear  = load_out;
        unique case (r_state)
            S_IDLE: begin
                acc_ctrl.capture = in_beat;
                if (in_beat) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                acc_ctrl.diff = 1'b1;
                n_state       = S_SQR;
            end
            S_SQR: begin
                acc_ctrl.square = 1'b1;
                n_state         = S_ACC;
            end
            S_ACC: begin
                acc_ctrl.update = 1'b1;
                n_state         = acc_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (set_empty) begin
                    n_state = S_MEAN;
                end else begin
                    ds_req.start     = 1'b1;
                    ds_req.sqrt_mode = 1'b1;
                    ds_req.steps     = enacc_pkg::ROOT_STEPS;
                    n_state          = S_ROOT;
                end
            end
            S_ROOT: begin
                // the finished root becomes the next dividend
                ds_operand = {ds_quo[enacc_pkg::ROOT_W-1:0],
                              {(enacc_pkg::SQ_SUM_W-enacc_pkg::ROOT_W){1'b0}}};
                if (ds_stat.done) begin
                    ds_req.start = 1'b1;
                    ds_req.steps = enacc_pkg::RMS_STEPS;
                    n_state      = S_RMS;
                end
            end
            S_RMS: begin
                ds_operand = {abs_sum,
                              {(enacc_pkg::SQ_SUM_W-enacc_pkg::ABS_SUM_W){1'b0}}};
                if (ds_stat.done) begin
                    ds_req.start = 1'b1;
                    ds_req.steps = enacc_pkg::MEAN_STEPS;
                    n_state      = S_MEAN;
                end
            end
            S_MEAN: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // closing pass finished: the mean quotient is final in the unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else if (load_out) begin
            r_emit <= 1'b0;
        end else if (r_state == S_MEAN && !ds_stat.busy && !ds_req.start) begin
            r_emit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RMS && ds_stat.done) begin
            r_rms <= ds_quo[enacc_pkg::ROOT_W-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_empty    <= set_empty;
            r_sat      <= overflow_seen;
            r_count    <= pairs_seen;
            r_max      <= set_empty ? '0 : abs_max;
            r_mean     <= set_empty ? '0 : ds_quo[enacc_pkg::DIFF_W-1:0];
            r_root_out <= set_empty ? '0 : r_rms;
        end
    end

    assign o_ready              = r_state == S_IDLE;
    assign o_valid              = r_out_valid;
    assign o_mean_abs_error     = r_mean;
    assign o_root_sq_over_count = r_root_out;
    assign o_max_abs_error      = r_max;
    assign o_pair_count         = r_count;
    assign o_empty_set          = r_empty;
    assign o_saturated          = r_sat;

    // the shared unit only runs during the closing pass
    a_unit_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !ds_stat.busy)
        else $error("shift-subtract unit busy while taking beats");

    // a finished step pass is only seen where the sequencer waits for it
    a_done_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ds_stat.done |-> (r_state == S_ROOT || r_state == S_RMS || r_state == S_MEAN))
        else $error("unit finished outside the closing pass");

    // count never passes the pair limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pairs_seen <= enacc_pkg::MAX_PAIRS)
        else $error("pair count beyond limit");

    // the running set is empty again right after a result is loaded
    a_clear_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (pairs_seen == '0 && abs_sum == '0 && !overflow_seen))
        else $error("statistics not cleared after result");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for error_norm_accumulator: directed table and random sets
module tb;

    localparam int SAMPLE_W  = enacc_pkg::SAMPLE_W;
    localparam int DIFF_W    = enacc_pkg::DIFF_W;
    localparam int ROOT_W    = enacc_pkg::ROOT_W;
    localparam int CNT_W     = enacc_pkg::CNT_W;
    localparam int ABS_SUM_W = enacc_pkg::ABS_SUM_W;
    localparam logic [CNT_W-1:0] MAX_PAIRS = enacc_pkg::MAX_PAIRS;

    localparam int WATCHDOG_LIMIT = 5000;
    // covers the closing pass of a last pair (root, two divisions) with margin
    localparam int SETTLE_CYCLES  = 150;
    localparam int RANDOM_BEATS   = 1520;
    localparam int EXP_DEPTH      = 64;
    localparam int DIRECTED_MAX   = 32;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam longint unsigned ABS_SUM_TOP = (64'd1 << ABS_SUM_W) - 64'd1;
    localparam longint unsigned SQ_SUM_TOP  = '1;

    // one result beat, field order matches the output ports
    typedef struct packed {
        logic [DIFF_W-1:0] mean_abs;
        logic [ROOT_W-1:0] root_sq;
        logic [DIFF_W-1:0] max_abs;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic              sat;
    } t_err_stats;

    // one row of the directed table: a register write or a pair beat
    typedef struct {
        bit                          is_cfg;
        bit                          cfg_val;
        logic signed [SAMPLE_W-1:0]  ref_v;
        logic signed [SAMPLE_W-1:0]  est_v;
        bit                          last;
        bit                          typed;
        t_err_stats                  want;
    } t_stim_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic                       i_cfg_data;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_reference_value;
    logic signed [SAMPLE_W-1:0] i_estimate_value;
    logic                       i_last_pair;
    logic                       o_valid;
    logic                       i_ready;
    logic [DIFF_W-1:0]          o_mean_abs_error;
    logic [ROOT_W-1:0]          o_root_sq_over_count;
    logic [DIFF_W-1:0]          o_max_abs_error;
    logic [CNT_W-1:0]           o_pair_count;
    logic                       o_empty_set;
    logic                       o_saturated;

    // predictor copy of the block's set state and register
    bit                 sign_match_cfg = 1'b0;
    longint unsigned    acc_abs_sum    = 0;
    longint unsigned    acc_sq_sum     = 0;
    logic [DIFF_W-1:0]  acc_abs_max    = '0;
    logic [CNT_W-1:0]   acc_pairs      = '0;
    bit                 acc_ovf        = 1'b0;

    // expected results in order, written by the driver and read by the checker
    t_err_stats exp_fifo [EXP_DEPTH];
    int         exp_wr       = 0;
    int         exp_rd       = 0;
    t_stim_row  directed [DIRECTED_MAX];
    int         n_directed   = 0;
    int         fail_count   = 0;
    int         quiet_cycles = 0;
    int         stall_left   = 0;
    bit         idle_on      = 1'b1;

    error_norm_accumulator dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_reference_value    (i_reference_value),
        .i_estimate_value     (i_estimate_value),
        .i_last_pair          (i_last_pair),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_mean_abs_error     (o_mean_abs_error),
        .o_root_sq_over_count (o_root_sq_over_count),
        .o_max_abs_error      (o_max_abs_error),
        .o_pair_count         (o_pair_count),
        .o_empty_set          (o_empty_set),
        .o_saturated          (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // bitwise integer square root, truncating
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    // fold one accepted pair into the predicted set state, close the set on last
    task automatic accumulate_pair(input logic signed [SAMPLE_W-1:0] ref_s,
                                   input logic signed [SAMPLE_W-1:0] est_s,
                                   input bit last, output bit has_result,
                                   output t_err_stats res);
        longint          r;
        longint          e;
        longint          diff;
        longint unsigned d;
        longint unsigned sq;
        r = ref_s;
        e = est_s;
        has_result = 1'b0;
        res = '0;
        if (acc_pairs >= MAX_PAIRS) begin
            // beyond the pair limit: dropped, only flagged
            acc_ovf = 1'b1;
        end else begin
            // zero counts as non-negative; negating the minimum clips to the maximum
            if (sign_match_cfg && ((r >= 0) != (e >= 0))) begin
                e = -e;
                if (e > longint'(SAMPLE_MAX)) e = SAMPLE_MAX;
            end
            diff = r - e;
            d = (diff < 0) ? -diff : diff;
            if (d > acc_abs_max) acc_abs_max = (d > 64'hFF_FFFF) ? '1 : DIFF_W'(d);
            acc_abs_sum += d;
            if (acc_abs_sum > ABS_SUM_TOP) acc_abs_sum = ABS_SUM_TOP;
            sq = d * d;
            if (acc_sq_sum > SQ_SUM_TOP - sq) begin
                acc_sq_sum = SQ_SUM_TOP;
                acc_ovf = 1'b1;
            end else begin
                acc_sq_sum += sq;
            end
            acc_pairs++;
        end
        if (last) begin
            has_result = 1'b1;
            if (acc_pairs == 0) begin
                res.empty = 1'b1;
            end else begin
                res.mean_abs = DIFF_W'(acc_abs_sum / acc_pairs);
                res.root_sq  = ROOT_W'(int_sqrt(acc_sq_sum) / acc_pairs);
                res.max_abs  = acc_abs_max;
                res.count    = acc_pairs;
            end
            res.sat = acc_ovf;
            acc_abs_sum = 0;
            acc_sq_sum  = 0;
            acc_abs_max = '0;
            acc_pairs   = '0;
            acc_ovf     = 1'b0;
        end
    endtask

    // drive one pair beat, hold it until taken, then predict; a typed row
    // supplies its own expectation in place of the predicted one
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] ref_s,
                             input logic signed [SAMPLE_W-1:0] est_s,
                             input bit last, input bit typed, input t_err_stats want);
        bit         has_result;
        t_err_stats res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_reference_value <= ref_s;
        i_estimate_value  <= est_s;
        i_last_pair       <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        accumulate_pair(ref_s, est_s, last, has_result, res);
        if (has_result) begin
            exp_fifo[exp_wr % EXP_DEPTH] = typed ? want : res;
            exp_wr++;
        end
    endtask

    // register write only with the block idle: all results out, closing pass done
    task automatic write_sign_match(input bit value);
        i_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sign_match_cfg = value;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int offset;
        offset = int'($urandom_range(0, 600)) - 300;
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'(offset);
            3:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // estimates are mostly near the reference, as a real estimator would be
    function automatic logic signed [SAMPLE_W-1:0] pick_estimate(
            input logic signed [SAMPLE_W-1:0] ref_s);
        int delta;
        delta = int'($urandom_range(0, 2000)) - 1000;
        case ($urandom_range(0, 8))
            0, 1, 2:    return pick_sample();
            3, 4, 5, 6: return ref_s + SAMPLE_W'(delta);
            7:          return ref_s;
            default:    return -ref_s;
        endcase
    endfunction

    // whole sets of random length until the beat quota is used up
    task automatic run_random_sets(input int quota);
        int                         sent;
        int                         len;
        logic signed [SAMPLE_W-1:0] r;
        logic signed [SAMPLE_W-1:0] e;
        sent = 0;
        while (sent < quota) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
                6, 7, 8:          len = $urandom_range(5, 16);
                default:          len = $urandom_range(17, 60);
            endcase
            for (int k = 0; k < len; k++) begin
                r = pick_sample();
                e = pick_estimate(r);
                send_pair(r, e, k == len - 1, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    function automatic t_stim_row pair_row(input logic signed [SAMPLE_W-1:0] ref_s,
                                           input logic signed [SAMPLE_W-1:0] est_s,
                                           input bit last);
        t_stim_row row;
        row = '{is_cfg: 1'b0, cfg_val: 1'b0, ref_v: ref_s, est_v: est_s, last: last,
                typed: 1'b0, want: '0};
        return row;
    endfunction

    // single-pair set whose result is known by inspection
    function automatic t_stim_row checked_row(input logic signed [SAMPLE_W-1:0] ref_s,
                                              input logic signed [SAMPLE_W-1:0] est_s,
                                              input logic [DIFF_W-1:0] d);
        t_stim_row row;
        row = pair_row(ref_s, est_s, 1'b1);
        row.typed = 1'b1;
        row.want  = '{mean_abs: d, root_sq: ROOT_W'(d), max_abs: d, count: CNT_W'(1),
                      empty: 1'b0, sat: 1'b0};
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input bit value);
        t_stim_row row;
        row = pair_row('0, '0, 1'b0);
        row.is_cfg  = 1'b1;
        row.cfg_val = value;
        return row;
    endfunction

    // append one row to the directed table
    task automatic add_row(input t_stim_row row);
        directed[n_directed] = row;
        n_directed++;
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input t_err_stats want, input t_err_stats got);
        compare_field("mean_abs_error", want.mean_abs, got.mean_abs);
        compare_field("root_sq_over_count", want.root_sq, got.root_sq);
        compare_field("max_abs_error", want.max_abs, got.max_abs);
        compare_field("pair_count", want.count, got.count);
        compare_field("empty_set", want.empty, got.empty);
        compare_field("saturated", want.sat, got.sat);
    endtask

    // result side: random stall bursts on ready, check every beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_rd == exp_wr) begin
                $display("%0t: result beat expected none, actual mean %0d count %0d",
                         $time, o_mean_abs_error, o_pair_count);
                fail_count++;
            end else begin
                check_result(exp_fifo[exp_rd % EXP_DEPTH],
                             {o_mean_abs_error, o_root_sq_over_count, o_max_abs_error,
                              o_pair_count, o_empty_set, o_saturated});
                exp_rd++;
            end
        end
        if (idle_on && stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog: too long with no beat on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= 1'b0;
        i_valid           <= 1'b0;
        i_reference_value <= '0;
        i_estimate_value  <= '0;
        i_last_pair       <= 1'b0;
        i_ready           <= 1'b0;

        // sign matching off: plain differences, full-scale extremes
        add_row(cfg_row(1'b0));
        add_row(checked_row('0, '0, '0));
        add_row(checked_row(SAMPLE_MAX, SAMPLE_MIN, '1));
        add_row(checked_row(SAMPLE_MIN, SAMPLE_MAX, '1));
        add_row(checked_row(SAMPLE_MIN, SAMPLE_MIN, '0));
        add_row(checked_row(24'sd1, '0, DIFF_W'(1)));
        add_row(pair_row(24'sd100, 24'sd50, 1'b0));
        add_row(pair_row(-24'sd200, 24'sd300, 1'b0));
        add_row(pair_row(24'sd5, 24'sd5, 1'b1));
        add_row(pair_row(-24'sd100, 24'sd200, 1'b0));
        add_row(pair_row(24'sd300, -24'sd50, 1'b1));
        // sign matching on: mismatched signs flip the estimate, zero is non-negative
        add_row(cfg_row(1'b1));
        add_row(checked_row(24'sd5, -24'sd3, DIFF_W'(2)));
        add_row(checked_row(-24'sd5, 24'sd3, DIFF_W'(2)));
        add_row(checked_row('0, -24'sd7, DIFF_W'(7)));
        add_row(checked_row(-24'sd1, '0, DIFF_W'(1)));
        // negating the minimum clips to the maximum
        add_row(checked_row(SAMPLE_MAX, SAMPLE_MIN, '0));
        add_row(checked_row(SAMPLE_MIN, SAMPLE_MAX, DIFF_W'(1)));
        add_row(checked_row(SAMPLE_MIN, -24'sd1, DIFF_W'(24'h7F_FFFF)));
        add_row(pair_row(24'sd1000, -24'sd900, 1'b0));
        add_row(pair_row(-24'sd70000, -24'sd1, 1'b0));
        add_row(pair_row('0, SAMPLE_MIN, 1'b0));
        add_row(pair_row(SAMPLE_MAX, 24'sd12345, 1'b1));
        add_row(cfg_row(1'b0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < n_directed; i++) begin
            row = directed[i];
            if (row.is_cfg) write_sign_match(row.cfg_val);
            else send_pair(row.ref_v, row.est_v, row.last, row.typed, row.want);
        end

        // random sets, register toggled per phase, the last phase with no idling
        for (int p = 0; p < 4; p++) begin
            write_sign_match(p[0] == 1'b0);
            idle_on = (p != 3);
            run_random_sets(RANDOM_BEATS / 4);
        end
        i_valid <= 1'b0;

        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/enacc_pkg.sv
rtl/core/enacc_accum.sv
rtl/core/enacc_shiftsub.sv
rtl/core/error_norm_accumulator.sv
tb/tb.sv
